// ===== design/ckr_pkg.sv =====
// Shared types and constants for the chord key recognizer.
package ckr_pkg;

	localparam int PATTERN_W   = 10;
	localparam int FINGERS_MAX = 5;
	localparam int IDX_W       = 6;
	localparam int STATUS_W    = 2;

	localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MATCH = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd2;

	// Search token handed from cell to cell along the table chain.
	typedef struct packed {
		logic                 valid;
		logic                 hit;
		logic [IDX_W-1:0]     idx;
		logic [PATTERN_W-1:0] key;
	} tok_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [IDX_W-1:0]     match_index;
		logic [PATTERN_W-1:0] chord_pattern;
	} rsp_t;

endpackage

// ===== design/ckr_in_if.sv =====
// Request channel: scan snapshot or layout load.
interface ckr_in_if import ckr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 req_type;
	logic [PATTERN_W-1:0] fingers;

	modport source (output valid, req_type, fingers, input ready);
	modport sink (input valid, req_type, fingers, output ready);
endinterface

// ===== design/ckr_out_if.sv =====
// Response channel: chord status, table index and released pattern.
interface ckr_out_if import ckr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [IDX_W-1:0]     match_index;
	logic [PATTERN_W-1:0] chord_pattern;

	modport source (output valid, status, match_index, chord_pattern, input ready);
	modport sink (input valid, status, match_index, chord_pattern, output ready);
endinterface

// ===== design/ckr_cell.sv =====
// One table cell: holds one chord entry and forwards the search token.
module ckr_cell import ckr_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	parameter int INDEX       = 0
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [PATTERN_W-1:0]                 wr_pat,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]     count,
	input  tok_t                                 tok_in,
	output tok_t                                 tok_out
);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [PATTERN_W-1:0] entry_q;
	logic                 used;
	tok_t                 tok_nxt;
	tok_t                 tok_q;

	// Write this entry when the fill count points here.
	always_ff @(posedge clk) begin
		if (wr_en && count == CW'(INDEX)) begin
			entry_q <= wr_pat;
		end
	end

	always_comb begin
		used    = count > CW'(INDEX);
		tok_nxt = tok_in;
		if (tok_in.valid && !tok_in.hit && used && entry_q == tok_in.key) begin
			tok_nxt.hit = 1'b1;
			tok_nxt.idx = IDX_W'(INDEX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;
endmodule

// ===== design/ckr_history.sv =====
// Chord history: length, first and last snapshot, release detection.
module ckr_history import ckr_pkg::*; #(
	parameter int HISTORY_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 upd,
	input  logic [PATTERN_W-1:0] pat,
	output logic                 release_ev,
	output logic [PATTERN_W-1:0] first_pat
);
	localparam int LW = $clog2(HISTORY_DEPTH + 1);

	logic [LW-1:0]        len_q, len1, len2, len_nxt;
	logic [PATTERN_W-1:0] first_q, last_q, last1, first_nxt, last_nxt;
	logic                 pressed;

	// A finger state that rises, or drops from 2 to 1, marks a new press.
	function automatic logic sw_pressed(input logic [PATTERN_W-1:0] prev,
			input logic [PATTERN_W-1:0] cur);
		logic       r;
		logic [1:0] a, b;
		r = 1'b0;
		for (int i = 0; i < FINGERS_MAX; i++) begin
			a = prev[2*i +: 2];
			b = cur[2*i +: 2];
			if (b > a || (a == 2'd2 && b == 2'd1)) begin
				r = 1'b1;
			end
		end
		return r;
	endfunction

	always_comb begin
		if (len_q >= LW'(HISTORY_DEPTH)) begin
			len1  = LW'(1);
			last1 = first_q;
		end else begin
			len1  = len_q;
			last1 = last_q;
		end
		pressed   = sw_pressed(last1, pat);
		len2      = len1;
		first_nxt = first_q;
		last_nxt  = last1;
		len_nxt   = '0;
		if (pat != '0) begin
			if (len1 != '0 && pressed) begin
				len2 = '0;
			end
			if (len2 == '0) begin
				first_nxt = pat;
			end
			last_nxt = pat;
			len_nxt  = len2 + LW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			first_q <= '0;
			last_q  <= '0;
		end else if (upd) begin
			len_q   <= len_nxt;
			first_q <= first_nxt;
			last_q  <= last_nxt;
		end
	end

	assign release_ev = (pat == '0) && (len_q != '0);
	assign first_pat  = first_q;
endmodule

// ===== design/chord_key_recognizer_top.sv =====
// Top level of the chord key recognizer: history, table chain and response register.
//
//   channel  | dir | payload                                  | transfer when
//   ---------+-----+------------------------------------------+----------------------
//   req      | in  | req_type, fingers                        | req.valid & req.ready
//   rsp      | out | status, match_index, chord_pattern       | rsp.valid & rsp.ready
//
// A load or a scan that ends no chord raises rsp.valid from ST_DONE once rsp is free.
// A release with a held chord sends the search token down the chain of TABLE_DEPTH
// cells, one cell per cycle, and the last cell reports.
// One request is in flight at a time; req.ready is high again once the result moves
// into the response register, so a waiting response does not block the next request.
// Reset clears the history, the fill count, the chain tokens and the control state;
// table entries are undefined until loaded and only entries below the count are read.
module chord_key_recognizer_top import ckr_pkg::*; #(
	parameter int HISTORY_DEPTH = 16,
	parameter int TABLE_DEPTH   = 64,
	parameter int FINGER_COUNT  = 5
) (
	input  logic      clk,
	input  logic      arst_n,
	ckr_in_if.sink    req,
	ckr_out_if.source rsp
);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int FB = (2 * FINGER_COUNT > PATTERN_W) ? PATTERN_W : 2 * FINGER_COUNT;
	localparam logic [PATTERN_W-1:0] FINGER_MASK = {PATTERN_W{1'b1}} >> (PATTERN_W - FB);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_DONE   = 2'd2;

	logic [1:0]           state_q;
	logic [CW-1:0]        count_q;
	rsp_t                 res_q;
	rsp_t                 rsp_q;
	logic                 rsp_valid_q;

	logic                 req_acc, load_acc, scan_acc, tbl_wr;
	logic [PATTERN_W-1:0] pat;
	logic                 release_ev;
	logic [PATTERN_W-1:0] first_pat;
	logic                 rsp_free;
	tok_t                 tok [0:TABLE_DEPTH];

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign load_acc  = req_acc && req.req_type;
	assign scan_acc  = req_acc && !req.req_type;
	// Drop finger bits beyond the configured finger count.
	assign pat       = req.fingers & FINGER_MASK;
	assign tbl_wr    = load_acc && (count_q < CW'(TABLE_DEPTH));
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	ckr_history #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_history (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (scan_acc),
		.pat       (pat),
		.release_ev(release_ev),
		.first_pat (first_pat)
	);

	// Launch a search token with the held chord's first pattern on release.
	always_comb begin
		tok[0]       = '0;
		tok[0].valid = scan_acc && release_ev;
		tok[0].key   = first_pat;
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		ckr_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.INDEX      (g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.wr_en  (tbl_wr),
			.wr_pat (pat),
			.count  (count_q),
			.tok_in (tok[g]),
			.tok_out(tok[g+1])
		);
	end

	// Advance the fill count on each accepted load until the table is full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (tbl_wr) begin
			count_q <= count_q + CW'(1);
		end
	end

	// Sequence one request: wait for the chain if searching, then hand off the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						res_q <= '0;
						if (scan_acc && release_ev) begin
							state_q <= ST_SEARCH;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_SEARCH: begin
					if (tok[TABLE_DEPTH].valid) begin
						res_q.chord_pattern <= tok[TABLE_DEPTH].key;
						if (tok[TABLE_DEPTH].hit) begin
							res_q.status      <= STATUS_MATCH;
							res_q.match_index <= tok[TABLE_DEPTH].idx;
						end else begin
							res_q.status      <= STATUS_MISS;
							res_q.match_index <= '0;
						end
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Response register: load when the result is ready and the slot frees up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (state_q == ST_DONE && rsp_free) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= res_q;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_q.status;
	assign rsp.match_index   = rsp_q.match_index;
	assign rsp.chord_pattern = rsp_q.chord_pattern;
endmodule

// ===== design/ckr_checker.sv =====
// Port-level checks for the chord key recognizer, bound to the top level.
module ckr_checker import ckr_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [STATUS_W-1:0]  rsp_status,
	input logic [IDX_W-1:0]     rsp_match_index,
	input logic [PATTERN_W-1:0] rsp_chord_pattern
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_match_index) && $stable(rsp_chord_pattern))
		else $error("response changed while stalled");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in flight");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == STATUS_NONE || rsp_status == STATUS_MATCH
			|| rsp_status == STATUS_MISS))
		else $error("unknown status code");

	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != STATUS_MATCH |-> rsp_match_index == '0)
		else $error("index set without a match");

	a_pattern_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STATUS_NONE |-> rsp_chord_pattern == '0)
		else $error("pattern set without a released chord");
endmodule

bind chord_key_recognizer_top ckr_checker u_ckr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_match_index  (rsp.match_index),
	.rsp_chord_pattern(rsp.chord_pattern)
);
